### sv/pms_pkg.sv
package pms_pkg;

   localparam int NOTE_DEPTH_DEFAULT = 64;
   localparam int TIMER_CLOCK_HZ_DEFAULT = 1000000;

   localparam int OP_W = 3;
   localparam int SLOT_W = 6;
   localparam int HZ_W = 16;
   localparam int MS_W = 16;
   localparam int LEN_W = 7;
   localparam int VOL_IN_W = 8;
   localparam int VOL_W = 7;
   localparam int PERIOD_W = 16;
   localparam int STATE_W = 2;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd999;
   localparam logic [PERIOD_W-1:0] PERIOD_MAX = 16'hFFFF;
   localparam logic [MS_W-1:0] ELAPSED_MAX = 16'hFFFF;
   localparam logic [VOL_W-1:0] VOLUME_RESET = 7'd50;
   localparam logic [VOL_W-1:0] VOLUME_MAX = 7'd100;

   // x/100 == (x*RECIP) >> 30 and x/200 == (x*RECIP) >> 31, exact for x < 2**23
   localparam int PROD_W = PERIOD_W + VOL_W;
   localparam int RECIP_W = 24;
   localparam int SCALED_W = PROD_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = 24'd10737419;
   localparam int SHIFT_100 = 30;
   localparam int SHIFT_200 = 31;

   typedef enum logic [OP_W-1:0] {
      OP_TICK   = 3'd0,
      OP_LOAD   = 3'd1,
      OP_PLAY   = 3'd2,
      OP_STOP   = 3'd3,
      OP_PAUSE  = 3'd4,
      OP_RESUME = 3'd5,
      OP_VOLUME = 3'd6
   } op_type;

   typedef enum logic [STATE_W-1:0] {
      MODE_STOPPED = 2'd0,
      MODE_PLAYING = 2'd1,
      MODE_PAUSED  = 2'd2
   } mode_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EVAL,
      S_TONE,
      S_DIV,
      S_PERIOD,
      S_MUL1,
      S_MUL2,
      S_RESP
   } fsm_type;

endpackage

### sv/pwm_melody_sequencer.sv
// Melody sequencer for a buzzer PWM.
// Request channel (req_*): one command per transfer. req_op selects tick (one
// millisecond elapsed), load note, play, stop, pause, resume or set volume; the
// other request fields are read only by the commands that use them.
// Response channel (rsp_*): exactly one response per request, in order, giving
// the PWM enable, period, compare, play state and current note after the command.
// Notes live in a single-port-read note RAM ({frequency, duration}) with a
// registered read; commands that need a note read it, then act on it.
// Path from request transfer to response valid, by the states each command passes:
//   load, stop, pause, undefined op, and anything ignored: straight to the response
//   resume, tick that does not advance or that ends the melody: evaluate, response
//   set volume while playing: two registered multiplies, then the response
//   play: tone, bit-serial period divider (one quotient bit per cycle), period,
//   then the two multiplies; a tick that starts a new note evaluates first, then
//   follows the play path; a rest note skips the divider, period and multiplies.
// One command is in flight at a time; req_ready is high while the sequencer idles.
// The response sits in an output register, so the next request can be taken while
// the receiver stalls; the sequencer then waits only when a second response is due.
// Reset stops playback, sets volume 50 and period 999; note RAM contents are
// undefined until loaded.
module pwm_melody_sequencer #(
   parameter int NOTE_DEPTH = pms_pkg::NOTE_DEPTH_DEFAULT,
   parameter int TIMER_CLOCK_HZ = pms_pkg::TIMER_CLOCK_HZ_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [pms_pkg::OP_W-1:0]      req_op,
   input  logic [pms_pkg::SLOT_W-1:0]    req_note_slot,
   input  logic [pms_pkg::HZ_W-1:0]      req_note_hz,
   input  logic [pms_pkg::MS_W-1:0]      req_note_ms,
   input  logic [pms_pkg::LEN_W-1:0]     req_melody_length,
   input  logic [pms_pkg::VOL_IN_W-1:0]  req_volume_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_pwm_on,
   output logic [pms_pkg::PERIOD_W-1:0]  rsp_pwm_period,
   output logic [pms_pkg::PERIOD_W-1:0]  rsp_pwm_compare,
   output logic [pms_pkg::STATE_W-1:0]   rsp_play_state,
   output logic [pms_pkg::SLOT_W-1:0]    rsp_current_note
);

   localparam int IDX_W = $clog2(NOTE_DEPTH);
   localparam int CNT_W = $clog2(NOTE_DEPTH + 1);
   localparam int DIV_W = $clog2(TIMER_CLOCK_HZ + 1);
   localparam int DIV_CW = $clog2(DIV_W + 1);
   localparam int ENTRY_W = pms_pkg::HZ_W + pms_pkg::MS_W;

   // note RAM
   logic [ENTRY_W-1:0] note_mem [NOTE_DEPTH];
   logic [ENTRY_W-1:0] rd_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [IDX_W-1:0]   mem_raddr;
   logic [ENTRY_W-1:0] mem_wdata;

   // control state
   pms_pkg::fsm_type  state_ff, state_in;
   pms_pkg::mode_type mode_ff, mode_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [pms_pkg::MS_W-1:0]     elapsed_ff, elapsed_in;
   logic [pms_pkg::VOL_W-1:0]    volume_ff, volume_in;
   logic [pms_pkg::PERIOD_W-1:0] period_ff, period_in;
   logic [pms_pkg::PERIOD_W-1:0] compare_ff, compare_in;
   logic oe_ff, oe_in;
   logic rsp_valid_ff, rsp_valid_in;

   // working registers
   pms_pkg::op_type op_ff, op_in;
   logic [DIV_W-1:0]             quo_ff, quo_in;
   logic [pms_pkg::HZ_W-1:0]     rem_ff, rem_in;
   logic [pms_pkg::HZ_W-1:0]     divisor_ff, divisor_in;
   logic [DIV_CW-1:0]            cnt_ff, cnt_in;
   logic [pms_pkg::VOL_W-1:0]    factor_ff, factor_in;
   logic                         halve_ff, halve_in;
   logic [pms_pkg::PROD_W-1:0]   prod_ff, prod_in;

   // response register
   logic                         rsp_load;
   logic                         rsp_on_ff;
   logic [pms_pkg::PERIOD_W-1:0] rsp_period_ff;
   logic [pms_pkg::PERIOD_W-1:0] rsp_compare_ff;
   logic [pms_pkg::STATE_W-1:0]  rsp_state_ff;
   logic [pms_pkg::SLOT_W-1:0]   rsp_note_ff;

   // combinational helpers
   logic                         req_xfer;
   pms_pkg::op_type              req_op_e;
   logic [pms_pkg::VOL_W-1:0]    vol_clamped;
   logic [CNT_W-1:0]             len_sat;
   logic [pms_pkg::HZ_W-1:0]     rd_hz;
   logic [pms_pkg::MS_W-1:0]     rd_ms;
   logic [pms_pkg::MS_W-1:0]     elapsed_inc;
   logic [CNT_W-1:0]             pos_next;
   logic [pms_pkg::HZ_W:0]       div_shift;
   logic                         div_bit;
   logic [31:0]                  quo_ext;
   logic [pms_pkg::SCALED_W-1:0] scaled;

   assign req_ready = (state_ff == pms_pkg::S_IDLE);
   assign req_xfer = req_valid && req_ready;
   assign req_op_e = pms_pkg::op_type'(req_op);

   assign rd_hz = rd_ff[ENTRY_W-1:pms_pkg::MS_W];
   assign rd_ms = rd_ff[pms_pkg::MS_W-1:0];

   assign vol_clamped = (req_volume_value > pms_pkg::VOL_IN_W'(pms_pkg::VOLUME_MAX))
                      ? pms_pkg::VOLUME_MAX : pms_pkg::VOL_W'(req_volume_value);
   assign len_sat = (32'(req_melody_length) > NOTE_DEPTH)
                  ? CNT_W'(NOTE_DEPTH) : CNT_W'(req_melody_length);

   assign elapsed_inc = (elapsed_ff != pms_pkg::ELAPSED_MAX) ? elapsed_ff + 1'b1 : elapsed_ff;
   assign pos_next = CNT_W'(pos_ff) + 1'b1;

   // restoring divider step
   assign div_shift = {rem_ff, quo_ff[DIV_W-1]};
   assign div_bit = (div_shift >= {1'b0, divisor_ff});
   assign quo_ext = 32'(quo_ff);

   assign scaled = pms_pkg::SCALED_W'(prod_ff) * pms_pkg::SCALED_W'(pms_pkg::RECIP);

   assign mem_waddr = IDX_W'(req_note_slot);
   assign mem_wdata = {req_note_hz, req_note_ms};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         note_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= note_mem[mem_raddr];
   end

   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff;
      pos_in = pos_ff;
      len_in = len_ff;
      elapsed_in = elapsed_ff;
      volume_in = volume_ff;
      period_in = period_ff;
      compare_in = compare_ff;
      oe_in = oe_ff;
      op_in = op_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      divisor_in = divisor_ff;
      cnt_in = cnt_ff;
      factor_in = factor_ff;
      halve_in = halve_ff;
      prod_in = prod_ff;
      mem_we = 1'b0;
      mem_raddr = pos_ff;
      rsp_load = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         pms_pkg::S_IDLE: begin
            if (req_xfer) begin
               op_in = req_op_e;
               state_in = pms_pkg::S_RESP;
               case (req_op_e)
                  pms_pkg::OP_TICK: begin
                     if (mode_ff == pms_pkg::MODE_PLAYING) begin
                        state_in = pms_pkg::S_EVAL;
                     end
                  end
                  pms_pkg::OP_LOAD: begin
                     mem_we = (32'(req_note_slot) < NOTE_DEPTH);
                  end
                  pms_pkg::OP_PLAY: begin
                     if (req_melody_length != '0) begin
                        len_in = len_sat;
                        pos_in = '0;
                        elapsed_in = '0;
                        mode_in = pms_pkg::MODE_PLAYING;
                        mem_raddr = '0;
                        state_in = pms_pkg::S_TONE;
                     end
                  end
                  pms_pkg::OP_STOP: begin
                     mode_in = pms_pkg::MODE_STOPPED;
                     len_in = '0;
                     pos_in = '0;
                     elapsed_in = '0;
                     oe_in = 1'b0;
                  end
                  pms_pkg::OP_PAUSE: begin
                     if (mode_ff == pms_pkg::MODE_PLAYING) begin
                        mode_in = pms_pkg::MODE_PAUSED;
                        oe_in = 1'b0;
                     end
                  end
                  pms_pkg::OP_RESUME: begin
                     if (mode_ff == pms_pkg::MODE_PAUSED) begin
                        mode_in = pms_pkg::MODE_PLAYING;
                        elapsed_in = '0;
                        state_in = pms_pkg::S_EVAL;
                     end
                  end
                  pms_pkg::OP_VOLUME: begin
                     volume_in = vol_clamped;
                     if (mode_ff == pms_pkg::MODE_PLAYING) begin
                        factor_in = vol_clamped >> 1;
                        halve_in = 1'b0;
                        state_in = pms_pkg::S_MUL1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         pms_pkg::S_EVAL: begin
            state_in = pms_pkg::S_RESP;
            if (op_ff == pms_pkg::OP_RESUME) begin
               if (rd_hz != '0) begin
                  oe_in = 1'b1;
               end
            end else if (elapsed_inc < rd_ms) begin
               elapsed_in = elapsed_inc;
            end else if (pos_next >= len_ff) begin
               // past the last note
               mode_in = pms_pkg::MODE_STOPPED;
               len_in = '0;
               pos_in = '0;
               elapsed_in = '0;
               oe_in = 1'b0;
            end else begin
               pos_in = IDX_W'(pos_next);
               elapsed_in = '0;
               mem_raddr = IDX_W'(pos_next);
               state_in = pms_pkg::S_TONE;
            end
         end

         pms_pkg::S_TONE: begin
            if (rd_hz == '0) begin
               // rest: PWM off, period and compare kept
               oe_in = 1'b0;
               state_in = pms_pkg::S_RESP;
            end else begin
               oe_in = 1'b1;
               divisor_in = rd_hz;
               quo_in = DIV_W'(TIMER_CLOCK_HZ);
               rem_in = '0;
               cnt_in = DIV_CW'(DIV_W);
               state_in = pms_pkg::S_DIV;
            end
         end

         pms_pkg::S_DIV: begin
            rem_in = div_bit ? pms_pkg::HZ_W'(div_shift - {1'b0, divisor_ff})
                             : div_shift[pms_pkg::HZ_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], div_bit};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == DIV_CW'(1)) begin
               state_in = pms_pkg::S_PERIOD;
            end
         end

         pms_pkg::S_PERIOD: begin
            if (quo_ext == 32'd0 || quo_ext > 32'd65536) begin
               period_in = pms_pkg::PERIOD_MAX;
            end else begin
               period_in = pms_pkg::PERIOD_W'(quo_ext - 32'd1);
            end
            factor_in = volume_ff;
            halve_in = 1'b1;
            state_in = pms_pkg::S_MUL1;
         end

         pms_pkg::S_MUL1: begin
            prod_in = pms_pkg::PROD_W'(period_ff) * pms_pkg::PROD_W'(factor_ff);
            state_in = pms_pkg::S_MUL2;
         end

         pms_pkg::S_MUL2: begin
            compare_in = halve_ff ? pms_pkg::PERIOD_W'(scaled >> pms_pkg::SHIFT_200)
                                  : pms_pkg::PERIOD_W'(scaled >> pms_pkg::SHIFT_100);
            state_in = pms_pkg::S_RESP;
         end

         pms_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = pms_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = pms_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pms_pkg::S_IDLE;
         mode_ff <= pms_pkg::MODE_STOPPED;
         pos_ff <= '0;
         len_ff <= '0;
         elapsed_ff <= '0;
         volume_ff <= pms_pkg::VOLUME_RESET;
         period_ff <= pms_pkg::PERIOD_RESET;
         compare_ff <= '0;
         oe_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff <= mode_in;
         pos_ff <= pos_in;
         len_ff <= len_in;
         elapsed_ff <= elapsed_in;
         volume_ff <= volume_in;
         period_ff <= period_in;
         compare_ff <= compare_in;
         oe_ff <= oe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      divisor_ff <= divisor_in;
      cnt_ff <= cnt_in;
      factor_ff <= factor_in;
      halve_ff <= halve_in;
      prod_ff <= prod_in;
      if (rsp_load) begin
         rsp_on_ff <= oe_ff;
         rsp_period_ff <= period_ff;
         rsp_compare_ff <= compare_ff;
         rsp_state_ff <= mode_ff;
         rsp_note_ff <= pms_pkg::SLOT_W'(pos_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pwm_on = rsp_on_ff;
   assign rsp_pwm_period = rsp_period_ff;
   assign rsp_pwm_compare = rsp_compare_ff;
   assign rsp_play_state = rsp_state_ff;
   assign rsp_current_note = rsp_note_ff;

endmodule
